[rtl/fca_pkg.sv]
`default_nettype none

package fca_pkg;

	// Operation codes carried by the op field of an item.
	localparam logic [2:0] OP_WRITE = 3'd0;
	localparam logic [2:0] OP_READ  = 3'd1;
	localparam logic [2:0] OP_ALLOC = 3'd2;
	localparam logic [2:0] OP_WALK  = 3'd3;
	localparam logic [2:0] OP_STATS = 3'd4;

	// Result status codes.
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_SHORT = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;

	// Statistics kinds.
	localparam logic [1:0] KIND_FREE  = 2'd0;
	localparam logic [1:0] KIND_RSVD  = 2'd1;
	localparam logic [1:0] KIND_ALLOC = 2'd2;

	// Table entry encodings.
	localparam logic [31:0] ENTRY_FREE = 32'h0000_0000;
	localparam logic [31:0] ENTRY_RSVD = 32'h0000_0001;
	localparam logic [31:0] END_MARK   = 32'hFFFF_FFFF;

	// Configuration register.
	localparam int         ENTRIES_W     = 11;
	localparam logic [10:0] ENTRIES_RESET = 11'd1024;
	localparam logic        REG_ENTRIES   = 1'b0;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_RD_EMIT,
		S_ERR,
		S_SCAN,
		S_SHORT,
		S_LNK_FIRST,
		S_LNK_PREV,
		S_LNK_NEXT,
		S_LNK_EMIT,
		S_WALK_RD,
		S_WALK_EMIT,
		S_ST0,
		S_ST1,
		S_ST2
	} state_t;

	typedef enum logic [2:0] {
		E_READ,
		E_RANGE,
		E_SHORT,
		E_ALLOC,
		E_WALK,
		E_STAT0,
		E_STAT1,
		E_STAT2
	} emit_sel_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_IDX,
		RD_CUR
	} rd_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      latch;
		logic      wr_item;
		rd_sel_t   rd_sel;
		logic      scan_start;
		logic      scan_step;
		logic      walk_adv;
		logic      lnk_first;
		logic      lnk_prev;
		logic      lnk_next;
		logic      lnk_write;
		logic      emit;
		emit_sel_t emit_sel;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [2:0] op;
		logic       len_zero;
		logic       idx_in_table;
		logic       idx_in_eff;
		logic       scan_done;
		logic       short_free;
		logic       k_last;
		logic       link_bad;
		logic       out_free;
	} sts_t;

endpackage

`default_nettype wire

[rtl/fca_ram.sv]
`default_nettype none

module fca_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/fca_ctrl.sv]
`default_nettype none

module fca_ctrl import fca_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_IDLE;
				case (sts.op)
					OP_WRITE: begin
						cmd.wr_item = 1'b1;
					end
					OP_READ: begin
						if (sts.idx_in_table) begin
							cmd.rd_sel = RD_IDX;
							state_d    = S_RD_EMIT;
						end else begin
							state_d = S_ERR;
						end
					end
					OP_ALLOC: begin
						if (!sts.len_zero) begin
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end
					end
					OP_WALK: begin
						if (sts.len_zero) begin
							state_d = S_IDLE;
						end else if (!sts.idx_in_eff) begin
							state_d = S_ERR;
						end else begin
							state_d = S_WALK_RD;
						end
					end
					OP_STATS: begin
						cmd.scan_start = 1'b1;
						state_d        = S_SCAN;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_RD_EMIT: begin
				if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = E_READ;
					state_d      = S_IDLE;
				end
			end
			S_ERR: begin
				if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = E_RANGE;
					state_d      = S_IDLE;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) begin
					if (sts.op == OP_ALLOC) begin
						state_d = sts.short_free ? S_SHORT : S_LNK_FIRST;
					end else begin
						state_d = S_ST0;
					end
				end
			end
			S_SHORT: begin
				if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = E_SHORT;
					state_d      = S_IDLE;
				end
			end
			S_LNK_FIRST: begin
				cmd.lnk_first = 1'b1;
				state_d       = S_LNK_PREV;
			end
			S_LNK_PREV: begin
				cmd.lnk_prev = 1'b1;
				state_d      = S_LNK_NEXT;
			end
			S_LNK_NEXT: begin
				cmd.lnk_next = !sts.k_last;
				state_d      = S_LNK_EMIT;
			end
			S_LNK_EMIT: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = E_ALLOC;
					cmd.lnk_write = 1'b1;
					state_d       = sts.k_last ? S_IDLE : S_LNK_NEXT;
				end
			end
			S_WALK_RD: begin
				if (!sts.k_last) begin
					cmd.rd_sel = RD_CUR;
				end
				state_d = S_WALK_EMIT;
			end
			S_WALK_EMIT: begin
				if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = E_WALK;
					if (sts.k_last || sts.link_bad) begin
						state_d = S_IDLE;
					end else begin
						cmd.walk_adv = 1'b1;
						state_d      = S_WALK_RD;
					end
				end
			end
			S_ST0: begin
				if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = E_STAT0;
					state_d      = S_ST1;
				end
			end
			S_ST1: begin
				if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = E_STAT1;
					state_d      = S_ST2;
				end
			end
			S_ST2: begin
				if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = E_STAT2;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/fca_dp.sv]
`default_nettype none

module fca_dp import fca_pkg::*; #(
	parameter int TABLE_DEPTH = 1024,
	parameter int MAX_CHAIN   = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [ENTRIES_W-1:0] entries_in_use,
	input  logic [2:0]           op,
	input  logic [9:0]           entry_index,
	input  logic [31:0]          entry_value,
	input  logic [6:0]           chain_length,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic                 result_ready,
	output logic                 result_valid,
	output logic [9:0]           block_number,
	output logic [31:0]          word,
	output logic [1:0]           stat_kind,
	output logic [1:0]           status,
	output logic                 last
);

	localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int PW  = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;
	localparam int LW  = $clog2(MAX_CHAIN + 1);
	localparam int EW0 = $clog2(TABLE_DEPTH + 1);
	localparam int EW  = (EW0 > ENTRIES_W) ? EW0 : ENTRIES_W;

	// Latched item.
	logic [2:0]    op_q;
	logic [9:0]    idx_q;
	logic [31:0]   val_q;
	logic [LW-1:0] n_q;

	// Chain and scan state.
	logic [LW-1:0] k_q;
	logic [LW-1:0] found_q;
	logic [AW-1:0] cur_q;
	logic [AW-1:0] prev_q;
	logic [EW-1:0] scan_q;
	logic          rd_v_s1;
	logic [AW-1:0] rd_addr_s1;
	logic [EW-1:0] free_q;
	logic [EW-1:0] rsvd_q;
	logic [EW-1:0] alloc_q;

	// Result register.
	logic          out_valid_q;
	logic [9:0]    block_q;
	logic [31:0]   word_q;
	logic [1:0]    kind_q;
	logic [1:0]    status_q;
	logic          last_q;

	logic [EW-1:0] eff;
	logic [LW-1:0] n_clamp;
	logic [LW-1:0] k_inc;
	logic          alloc_mode;
	logic          k_last;
	logic          link_bad;
	logic          scan_more;
	logic          scan_issue;
	logic          hit;
	logic          idx_in_table;
	logic          out_free;

	logic          tbl_we;
	logic [AW-1:0] tbl_waddr;
	logic [31:0]   tbl_wdata;
	logic          tbl_re;
	logic [AW-1:0] tbl_raddr;
	logic [31:0]   tbl_rdata;

	logic          pk_we;
	logic [PW-1:0] pk_waddr;
	logic          pk_re;
	logic [PW-1:0] pk_raddr;
	logic [AW-1:0] pk_rdata;

	logic [AW-1:0] e_block;
	logic [31:0]   e_word;
	logic [1:0]    e_kind;
	logic [1:0]    e_status;
	logic          e_last;

	// Effective table size and per-item conditions.
	always_comb begin
		eff = (EW'(entries_in_use) < EW'(TABLE_DEPTH)) ? EW'(entries_in_use)
			: EW'(TABLE_DEPTH);
		n_clamp = (chain_length > 7'(MAX_CHAIN)) ? LW'(MAX_CHAIN) : LW'(chain_length);
		k_inc        = k_q + LW'(1);
		alloc_mode   = (op_q == OP_ALLOC);
		k_last       = (k_inc == n_q);
		link_bad     = !k_last && (tbl_rdata >= 32'(eff));
		idx_in_table = (EW'(idx_q) < EW'(TABLE_DEPTH));
		scan_more    = (scan_q < eff) && !(alloc_mode && (found_q == n_q));
		scan_issue   = cmd.scan_step && scan_more;
		hit          = rd_v_s1 && alloc_mode && (tbl_rdata == ENTRY_FREE)
			&& (found_q < n_q);
		out_free     = !out_valid_q || result_ready;
	end

	// Status toward the controller.
	always_comb begin
		sts.op           = op_q;
		sts.len_zero     = (n_q == '0);
		sts.idx_in_table = idx_in_table;
		sts.idx_in_eff   = (EW'(idx_q) < eff);
		sts.scan_done    = !scan_more && !rd_v_s1;
		sts.short_free   = (found_q < n_q);
		sts.k_last       = k_last;
		sts.link_bad     = link_bad;
		sts.out_free     = out_free;
	end

	// Table ports: all reads share the read port, all writes share the write port.
	always_comb begin
		tbl_re = scan_issue || (cmd.rd_sel != RD_NONE);
		if (scan_issue) begin
			tbl_raddr = AW'(scan_q);
		end else if (cmd.rd_sel == RD_CUR) begin
			tbl_raddr = cur_q;
		end else begin
			tbl_raddr = AW'(idx_q);
		end
		tbl_we = (cmd.wr_item && idx_in_table) || cmd.lnk_write;
		if (cmd.lnk_write) begin
			tbl_waddr = prev_q;
			tbl_wdata = k_last ? END_MARK : 32'(pk_rdata);
		end else begin
			tbl_waddr = AW'(idx_q);
			tbl_wdata = val_q;
		end
	end

	// Picked block list: filled by the scan, read back in order while linking.
	always_comb begin
		pk_we    = hit;
		pk_waddr = PW'(found_q);
		pk_re    = cmd.lnk_first || cmd.lnk_next;
		pk_raddr = cmd.lnk_first ? '0 : PW'(k_inc);
	end

	fca_ram #(
		.WIDTH(32),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(tbl_waddr),
		.wdata(tbl_wdata),
		.re   (tbl_re),
		.raddr(tbl_raddr),
		.rdata(tbl_rdata)
	);

	fca_ram #(
		.WIDTH(AW),
		.DEPTH(MAX_CHAIN)
	) u_picked (
		.clk  (clk),
		.we   (pk_we),
		.waddr(pk_waddr),
		.wdata(rd_addr_s1),
		.re   (pk_re),
		.raddr(pk_raddr),
		.rdata(pk_rdata)
	);

	// Control flops: scan read valid and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= scan_issue;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item capture, counters and chain pointers.
	always_ff @(posedge clk) begin
		rd_addr_s1 <= AW'(scan_q);
		if (cmd.latch) begin
			op_q  <= op;
			idx_q <= entry_index;
			val_q <= entry_value;
			n_q   <= n_clamp;
			cur_q <= AW'(entry_index);
			k_q   <= '0;
		end
		if (cmd.scan_start) begin
			scan_q  <= '0;
			found_q <= '0;
			free_q  <= '0;
			rsvd_q  <= '0;
			alloc_q <= '0;
		end else begin
			if (scan_issue) begin
				scan_q <= scan_q + EW'(1);
			end
			if (hit) begin
				found_q <= found_q + LW'(1);
			end
			if (rd_v_s1 && !alloc_mode) begin
				if (tbl_rdata == ENTRY_FREE) begin
					free_q <= free_q + EW'(1);
				end else if (tbl_rdata == ENTRY_RSVD) begin
					rsvd_q <= rsvd_q + EW'(1);
				end else begin
					alloc_q <= alloc_q + EW'(1);
				end
			end
		end
		if (cmd.walk_adv) begin
			cur_q <= AW'(tbl_rdata);
			k_q   <= k_inc;
		end
		if (cmd.lnk_first) begin
			k_q <= '0;
		end
		if (cmd.lnk_prev) begin
			prev_q <= pk_rdata;
		end
		if (cmd.lnk_write && !k_last) begin
			prev_q <= pk_rdata;
			k_q    <= k_inc;
		end
	end

	// Result fields for each kind of beat.
	always_comb begin
		e_block  = '0;
		e_word   = '0;
		e_kind   = KIND_FREE;
		e_status = STATUS_OK;
		e_last   = 1'b1;
		unique case (cmd.emit_sel)
			E_READ: begin
				e_word = tbl_rdata;
			end
			E_RANGE: begin
				e_status = STATUS_RANGE;
			end
			E_SHORT: begin
				e_status = STATUS_SHORT;
			end
			E_ALLOC: begin
				e_block = prev_q;
				e_last  = k_last;
			end
			E_WALK: begin
				e_block  = cur_q;
				e_status = link_bad ? STATUS_RANGE : STATUS_OK;
				e_last   = k_last || link_bad;
			end
			E_STAT0: begin
				e_word = 32'(free_q);
				e_kind = KIND_FREE;
				e_last = 1'b0;
			end
			E_STAT1: begin
				e_word = 32'(rsvd_q);
				e_kind = KIND_RSVD;
				e_last = 1'b0;
			end
			E_STAT2: begin
				e_word = 32'(alloc_q);
				e_kind = KIND_ALLOC;
			end
			default: begin
				e_last = 1'b1;
			end
		endcase
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			block_q  <= 10'(e_block);
			word_q   <= e_word;
			kind_q   <= e_kind;
			status_q <= e_status;
			last_q   <= e_last;
		end
	end

	assign result_valid = out_valid_q;
	assign block_number = block_q;
	assign word         = word_q;
	assign stat_kind    = kind_q;
	assign status       = status_q;
	assign last         = last_q;

endmodule

`default_nettype wire

[rtl/fat_chain_allocator.sv]
// File allocation table chain allocator.
// Items enter on the item channel (item_valid/item_ready) and results leave on
// the result channel (result_valid/result_ready); each beat is one item or one
// result, and the final result of an item has last set. The single register,
// entries_in_use at byte address 0, is written over the APB port; the user
// must write it only while idle, as the block itself does not enforce this.
// One item is worked on at a time. A write gives no result; a read result
// comes from the registered table read port. Allocate and stats scan the
// table through one memory read port, one entry per cycle, over the effective
// entry count (at most TABLE_DEPTH). An allocation then links the chain,
// writing each link and sending each block's number; a walk does one table
// read per block. Stats send three beats after the scan. Results pass through
// one output register: a new item is taken while the last result still waits,
// and a stalled receiver holds the block in its current step without losing
// work. Reset sets entries_in_use to 1024 and returns the controller to idle;
// the table contents are not cleared and must be loaded by write items before
// use.
`default_nettype none

module fat_chain_allocator import fca_pkg::*; #(
	parameter int TABLE_DEPTH = 1024,
	parameter int MAX_CHAIN   = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [2:0]  op,
	input  logic [9:0]  entry_index,
	input  logic [31:0] entry_value,
	input  logic [6:0]  chain_length,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [9:0]  block_number,
	output logic [31:0] word,
	output logic [1:0]  stat_kind,
	output logic [1:0]  status,
	output logic        last
);

	logic [ENTRIES_W-1:0] entries_q;
	logic                 reg_wr;
	cmd_t                 cmd;
	sts_t                 sts;

	// Configuration register, written in the access phase.
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_ENTRIES) ? 32'(entries_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= ENTRIES_RESET;
		end else if (reg_wr && (paddr[2] == REG_ENTRIES)) begin
			entries_q <= pwdata[ENTRIES_W-1:0];
		end
	end

	fca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fca_dp #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.MAX_CHAIN  (MAX_CHAIN)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.entries_in_use(entries_q),
		.op            (op),
		.entry_index   (entry_index),
		.entry_value   (entry_value),
		.chain_length  (chain_length),
		.cmd           (cmd),
		.sts           (sts),
		.result_ready  (result_ready),
		.result_valid  (result_valid),
		.block_number  (block_number),
		.word          (word),
		.stat_kind     (stat_kind),
		.status        (status),
		.last          (last)
	);

endmodule

`default_nettype wire

[tb/sv/fat_chain_allocator_tb.sv]
`default_nettype none

module fat_chain_allocator_tb;
	import fca_pkg::*;

	localparam int TABLE_DEPTH = 1024;
	localparam int MAX_CHAIN = 64;
	localparam int LOADED_ENTRIES = 72;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned LONG_HOLD_CYCLES = 600;
	localparam int unsigned ITEMS_PER_PHASE = 4;
	localparam logic [2:0] ENTRIES_ADDR = 3'(4 * REG_ENTRIES);

	// Op codes that the block decodes as no operation.
	localparam logic [2:0] OP_SPARE_A = 3'd5;
	localparam logic [2:0] OP_SPARE_B = 3'd6;
	localparam logic [2:0] OP_SPARE_C = 3'd7;

	// One result beat as the block should present it.
	typedef struct {
		logic [9:0]  block;
		logic [31:0] word;
		logic [1:0]  kind;
		logic [1:0]  status;
		logic        last;
	} fat_beat_t;

	typedef enum logic [1:0] {
		RX_STEADY,
		RX_COIN,
		RX_SPARSE,
		RX_PERIODIC
	} rx_pattern_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [2:0]  op = OP_WRITE;
	logic [9:0]  entry_index = '0;
	logic [31:0] entry_value = '0;
	logic [6:0]  chain_length = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [9:0]  block_number;
	logic [31:0] word;
	logic [1:0]  stat_kind;
	logic [1:0]  status;
	logic        last;

	// Shadow copy of the table and the register.
	logic [31:0] fat_shadow [TABLE_DEPTH];
	logic [10:0] entries_cfg = ENTRIES_RESET;
	logic [9:0]  chain_heads [$];
	fat_beat_t   awaited_results [$];
	fat_beat_t   head_beat;

	int unsigned items_sent = 0;
	int unsigned beats_seen = 0;
	int unsigned allocations = 0;
	int unsigned shortages = 0;
	int unsigned walks_sent = 0;
	int unsigned range_stops = 0;
	int unsigned settings_applied = 0;
	int unsigned error_count = 0;
	int unsigned burst_left = 0;
	int unsigned cycles_run = 0;

	rx_pattern_e rx_pattern = RX_STEADY;
	int unsigned rx_pattern_left = 0;
	int unsigned rx_hold_left = 0;
	int unsigned rx_phase = 0;
	bit          long_hold_pending = 1'b0;

	fat_chain_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.op(op),
		.entry_index(entry_index),
		.entry_value(entry_value),
		.chain_length(chain_length),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.block_number(block_number),
		.word(word),
		.stat_kind(stat_kind),
		.status(status),
		.last(last)
	);

	always #2 clk = ~clk;

	// Queue one expected result beat.
	function automatic void queue_result_beat(logic [9:0] blk, logic [31:0] value,
			logic [1:0] kind, logic [1:0] code, logic fin);
		fat_beat_t beat;
		beat.block = blk;
		beat.word = value;
		beat.kind = kind;
		beat.status = code;
		beat.last = fin;
		awaited_results.push_back(beat);
	endfunction

	// Work out the results of one accepted item and update the shadow table.
	function automatic void predict_fat_results(logic [2:0] code, logic [9:0] idx,
			logic [31:0] value, logic [6:0] len);
		int unsigned n;
		int unsigned found;
		int unsigned k;
		int unsigned i;
		int unsigned nfree;
		int unsigned nrsvd;
		int unsigned nalloc;
		logic [31:0] eff;
		logic [31:0] cur;
		logic [31:0] link;
		logic [9:0]  picks [MAX_CHAIN];
		n = (32'(len) > MAX_CHAIN) ? MAX_CHAIN : 32'(len);
		eff = (32'(entries_cfg) < 32'(TABLE_DEPTH)) ? 32'(entries_cfg) : 32'(TABLE_DEPTH);
		case (code)
			OP_WRITE: begin
				fat_shadow[idx] = value;
			end
			OP_READ: begin
				queue_result_beat('0, fat_shadow[idx], KIND_FREE, STATUS_OK, 1'b1);
			end
			OP_ALLOC: begin
				if (n == 0)
					return;
				allocations++;
				found = 0;
				for (i = 0; i < eff && found < n; i++) begin
					if (fat_shadow[10'(i)] == ENTRY_FREE) begin
						picks[6'(found)] = i[9:0];
						found++;
					end
				end
				if (found < n) begin
					shortages++;
					queue_result_beat('0, '0, KIND_FREE, STATUS_SHORT, 1'b1);
					return;
				end
				// Link each picked entry to the next and close the chain.
				for (k = 0; k + 1 < n; k++)
					fat_shadow[picks[6'(k)]] = 32'(picks[6'(k + 1)]);
				fat_shadow[picks[6'(n - 1)]] = END_MARK;
				for (k = 0; k < n; k++)
					queue_result_beat(picks[6'(k)], '0, KIND_FREE, STATUS_OK, k + 1 == n);
				chain_heads.push_back(picks[0]);
				if (chain_heads.size() > 32)
					void'(chain_heads.pop_front());
			end
			OP_WALK: begin
				if (n == 0)
					return;
				walks_sent++;
				if (32'(idx) >= eff) begin
					range_stops++;
					queue_result_beat('0, '0, KIND_FREE, STATUS_RANGE, 1'b1);
					return;
				end
				cur = 32'(idx);
				for (k = 0; k < n; k++) begin
					if (k + 1 == n) begin
						queue_result_beat(cur[9:0], '0, KIND_FREE, STATUS_OK, 1'b1);
						return;
					end
					link = fat_shadow[cur[9:0]];
					if (link >= eff) begin
						range_stops++;
						queue_result_beat(cur[9:0], '0, KIND_FREE, STATUS_RANGE, 1'b1);
						return;
					end
					queue_result_beat(cur[9:0], '0, KIND_FREE, STATUS_OK, 1'b0);
					cur = link;
				end
			end
			OP_STATS: begin
				nfree = 0;
				nrsvd = 0;
				nalloc = 0;
				for (i = 0; i < eff; i++) begin
					if (fat_shadow[10'(i)] == ENTRY_FREE)
						nfree++;
					else if (fat_shadow[10'(i)] == ENTRY_RSVD)
						nrsvd++;
					else
						nalloc++;
				end
				queue_result_beat('0, nfree, KIND_FREE, STATUS_OK, 1'b0);
				queue_result_beat('0, nrsvd, KIND_RSVD, STATUS_OK, 1'b0);
				queue_result_beat('0, nalloc, KIND_ALLOC, STATUS_OK, 1'b1);
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			error_count++;
		end
	endfunction

	// Sender pacing: bursts of random length separated by short gaps.
	task automatic pace_sender();
		int unsigned gap;
		if (burst_left != 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 6);
		end
	endtask

	// Offer one item and hold it until the block takes the beat.
	task automatic offer_item(input logic [2:0] code, input logic [9:0] idx,
			input logic [31:0] value, input logic [6:0] len);
		logic taken;
		item_valid <= 1'b1;
		op <= code;
		entry_index <= idx;
		entry_value <= value;
		chain_length <= len;
		do begin
			@(negedge clk);
			taken = item_ready;
			@(posedge clk);
		end while (!taken);
		items_sent++;
		predict_fat_results(code, idx, value, len);
		pace_sender();
	endtask

	// Stop sending, wait for every expected beat, then let the block settle.
	task automatic drain_results();
		item_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write entries_in_use over APB while idle, then read it back.
	task automatic program_entries_in_use(input logic [10:0] setting);
		logic done;
		logic [31:0] readback;
		drain_results();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ENTRIES_ADDR;
		pwdata <= {21'd0, setting};
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			done = pready;
			@(posedge clk);
		end while (!done);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			done = pready;
			readback = prdata;
			@(posedge clk);
		end while (!done);
		psel <= 1'b0;
		penable <= 1'b0;
		compare_field("entries_in_use", 32'(setting), 32'(readback[10:0]));
		entries_cfg = setting;
		settings_applied++;
	endtask

	// Narrow the scanned range to the loaded entries, then load them: mostly
	// free, with every twelfth entry reserved, a link, an odd value or an end mark.
	task automatic load_table();
		int unsigned kind;
		logic [31:0] value;
		program_entries_in_use(11'(LOADED_ENTRIES));
		kind = 0;
		for (int i = 0; i < LOADED_ENTRIES; i++) begin
			if (i % 12 != 11) begin
				value = ENTRY_FREE;
			end else begin
				case (kind % 4)
					0: value = ENTRY_RSVD;
					1: value = 32'($urandom_range(2, LOADED_ENTRIES - 1));
					2: value = $urandom;
					default: value = END_MARK;
				endcase
				kind++;
			end
			offer_item(OP_WRITE, i[9:0], value, 7'($urandom));
		end
		drain_results();
	endtask

	// Reads at both ends of the loaded range and a write at the table top read back.
	task automatic check_entry_access();
		offer_item(OP_READ, 10'd0, $urandom, 7'd0);
		offer_item(OP_READ, 10'(LOADED_ENTRIES - 1), $urandom, 7'd127);
		offer_item(OP_WRITE, 10'd1023, 32'hA5A5_5A5A, 7'd1);
		offer_item(OP_READ, 10'd1023, '0, 7'd1);
		drain_results();
	endtask

	// Zero, single and saturated full-length chains, then a shortage.
	task automatic check_allocation();
		offer_item(OP_ALLOC, 10'($urandom), $urandom, 7'd0);
		offer_item(OP_ALLOC, 10'($urandom), $urandom, 7'd1);
		offer_item(OP_ALLOC, 10'($urandom), $urandom, 7'd127);
		program_entries_in_use(11'd16);
		offer_item(OP_ALLOC, 10'($urandom), $urandom, 7'd17);
		program_entries_in_use(11'(LOADED_ENTRIES));
	endtask

	// Walks: full chain, past the end mark, zero length, a bad start, and a
	// link at the table size while the register asks for more than the table.
	task automatic check_chain_walk();
		offer_item(OP_WALK, chain_heads[1], $urandom, 7'd127);
		offer_item(OP_WALK, chain_heads[0], $urandom, 7'd3);
		offer_item(OP_WALK, chain_heads[1], $urandom, 7'd0);
		program_entries_in_use(11'd16);
		offer_item(OP_WALK, 10'd1023, $urandom, 7'd5);
		offer_item(OP_WRITE, 10'd1023, 32'(TABLE_DEPTH), 7'd1);
		program_entries_in_use(11'd2047);
		offer_item(OP_WALK, 10'd1023, $urandom, 7'd2);
		program_entries_in_use(11'(LOADED_ENTRIES));
	endtask

	task automatic check_stats_and_spare_ops();
		offer_item(OP_STATS, 10'($urandom), $urandom, 7'($urandom));
		offer_item(OP_SPARE_A, 10'($urandom), $urandom, 7'd5);
		offer_item(OP_SPARE_B, 10'($urandom), $urandom, 7'd5);
		offer_item(OP_SPARE_C, 10'($urandom), $urandom, 7'd5);
		drain_results();
	endtask

	// The receiver holds off for a long stretch while items keep coming.
	task automatic check_result_backpressure();
		long_hold_pending = 1'b1;
		offer_item(OP_WALK, chain_heads[1], '0, 7'd20);
		offer_item(OP_READ, 10'($urandom_range(0, LOADED_ENTRIES - 1)), '0, 7'd0);
		offer_item(OP_WALK, chain_heads[1], '0, 7'd127);
		offer_item(OP_STATS, '0, '0, 7'd0);
		offer_item(OP_WALK, 10'($urandom), '0, 7'd20);
		offer_item(OP_READ, 10'($urandom_range(0, LOADED_ENTRIES - 1)), '0, 7'd0);
		offer_item(OP_ALLOC, '0, '0, 7'd5);
		offer_item(OP_WALK, chain_heads[0], '0, 7'd20);
		drain_results();
	endtask

	// Random mix over several register settings, walks mostly on real chains.
	task automatic run_random_traffic();
		logic [10:0] phase_setting [4];
		int unsigned counted;
		int unsigned pick;
		int unsigned shape;
		logic [31:0] value;
		logic [9:0]  start;
		logic [6:0]  len;
		phase_setting = '{11'(LOADED_ENTRIES), 11'd40, 11'd1, 11'd0};
		foreach (phase_setting[p]) begin
			program_entries_in_use(phase_setting[p]);
			counted = 0;
			while (counted < ITEMS_PER_PHASE) begin
				pick = $urandom_range(0, 99);
				len = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
					: 7'($urandom_range(1, 12));
				if (pick < 15) begin
					shape = $urandom_range(0, 5);
					case (shape)
						0, 1, 2: value = ENTRY_FREE;
						3: value = ENTRY_RSVD;
						4: value = 32'($urandom_range(2, LOADED_ENTRIES - 1));
						default: value = $urandom;
					endcase
					offer_item(OP_WRITE, 10'($urandom_range(0, LOADED_ENTRIES - 1)), value,
						len);
					counted++;
				end else if (pick < 30) begin
					offer_item(OP_READ, 10'($urandom_range(0, LOADED_ENTRIES - 1)), $urandom,
						len);
					counted++;
				end else if (pick < 50) begin
					offer_item(OP_ALLOC, 10'($urandom), $urandom, len);
					counted++;
				end else if (pick < 80) begin
					if (chain_heads.size() != 0 && $urandom_range(0, 9) < 7) begin
						start = chain_heads[$urandom_range(0, chain_heads.size() - 1)];
						len = ($urandom_range(0, 3) == 0) ? 7'd127
							: 7'($urandom_range(1, 20));
					end else begin
						start = 10'($urandom);
					end
					offer_item(OP_WALK, start, $urandom, len);
					counted++;
				end else if (pick < 92) begin
					offer_item(OP_STATS, 10'($urandom), $urandom, len);
					counted++;
				end else begin
					offer_item(3'($urandom_range(OP_SPARE_A, OP_SPARE_C)), 10'($urandom),
						$urandom, len);
				end
			end
		end
		drain_results();
	endtask

	// Result checker: a beat is taken at the next rising edge.
	always @(negedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			beats_seen++;
			if (awaited_results.size() == 0) begin
				$error("result beat with no item waiting for it: block %0d word 0x%0h",
					block_number, word);
				error_count++;
			end else begin
				head_beat = awaited_results.pop_front();
				compare_field("block_number", 32'(head_beat.block), 32'(block_number));
				compare_field("word", head_beat.word, word);
				compare_field("stat_kind", 32'(head_beat.kind), 32'(stat_kind));
				compare_field("status", 32'(head_beat.status), 32'(status));
				compare_field("last", 32'(head_beat.last), 32'(last));
			end
		end
	end

	// Receiver: shifting stall patterns, plus one long hold-off on request.
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (long_hold_pending || rx_hold_left != 0) begin
			if (long_hold_pending) begin
				long_hold_pending = 1'b0;
				rx_hold_left = LONG_HOLD_CYCLES;
			end
			rx_hold_left--;
			result_ready <= 1'b0;
		end else begin
			if (rx_pattern_left == 0) begin
				rx_pattern = rx_pattern_e'($urandom_range(0, 3));
				rx_pattern_left = $urandom_range(8, 96);
			end
			rx_pattern_left--;
			rx_phase++;
			case (rx_pattern)
				RX_STEADY: result_ready <= 1'b1;
				RX_COIN: result_ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: result_ready <= ($urandom_range(0, 4) == 0);
				default: result_ready <= (rx_phase % 3 != 0);
			endcase
		end
	end

	// Watchdog on the total cycle count.
	initial begin
		while (cycles_run < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles_run++;
		end
		$display("Timed out after %0d cycles with %0d beats outstanding", cycles_run,
			awaited_results.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		load_table();
		check_entry_access();
		check_allocation();
		check_chain_walk();
		check_stats_and_spare_ops();
		check_result_backpressure();
		run_random_traffic();
		$display("Covered %0d items and %0d result beats: %0d allocations (%0d short),",
			items_sent, beats_seen, allocations, shortages);
		$display("%0d walks (%0d stopped on range), %0d register settings, one long stall.",
			walks_sent, range_stops, settings_applied);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire

[fat_chain_allocator.f]
rtl/fca_pkg.sv
rtl/fca_ram.sv
rtl/fca_ctrl.sv
rtl/fca_dp.sv
rtl/fat_chain_allocator.sv
tb/sv/fat_chain_allocator_tb.sv
